// File: rtl/angle_bias_kalman_filter_core_assert.svh
// Assertion macros for the checker file.
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ABK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ABK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// Types and constants of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MEAS_NOISE  = 2'd2;

  localparam logic [30:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [30:0] BIAS_NOISE_RST  = 31'd50332;
  localparam logic [30:0] MEAS_NOISE_RST  = 31'd8388608;
  localparam logic signed [31:0] Q24_ONE  = 32'sd16777216;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PA, ST_P11DT, ST_CDT, ST_P11DT2, ST_PRED,
    ST_DIV0_GO, ST_DIV0_WAIT, ST_DIV1_GO, ST_DIV1_WAIT, ST_GAIN,
    ST_KY0, ST_KY1, ST_K0P, ST_K0C, ST_K1P, ST_K1C, ST_UPD, ST_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// File: rtl/abkf_if.sv
// ----------------------------------------------------------------------------
// abkf_if
// Valid/ready channel carrying a payload of parameterised type.
// ----------------------------------------------------------------------------
interface abkf_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/angle_bias_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// Two-state angle/bias Kalman filter around one multiplier and one divider.
// ----------------------------------------------------------------------------
// Each item runs the predict steps, two gain divisions on the shared divider
// and the correct steps before its result is valid. With a non-positive
// innovation variance the divisions are skipped.
// Not ready while an item is in flight or its result waits.
// Reset (synchronous, rst_n low): state zero, variances 1.0, noise registers
// to their defaults.
module angle_bias_kalman_filter_core (
  input  logic clk,
  input  logic rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [23:0] in_time_step,
  input  logic signed [31:0] in_measured_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic       out_valid,
  input  logic       out_ready,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_bias_estimate,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [abkf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  abkf_pkg::state_t st_r, st_nxt;

  // Noise registers
  logic [30:0] qa_r, qb_r, rm_r;
  // Filter state
  logic signed [31:0] ang_r, bia_r, p00_r, pc_r, p11_r;
  // Item and intermediates
  logic [23:0] dt_r;
  logic signed [31:0] meas_r, rate_r;
  logic signed [31:0] pa_r, pp00_r, ppc_r, pp11_r, p11dt_r, k0_r, k1_r;
  logic signed [65:0] cdt_r;
  logic signed [33:0] y_r;
  logic signed [65:0] ky0_r, ky1_r, k0p_r, k0c_r, k1p_r;
  logic               spos_r;

  // Shared multiplier
  logic signed [33:0] ma, mb;
  logic               msh30;
  logic signed [65:0] mp;
  abkf_mul u_mul (.clk(clk), .a(ma), .b(mb), .sh30(msh30), .p(mp));

  // Shared divider
  logic        dstart, dbusy;
  logic signed [31:0] dnum;
  logic signed [63:0] dq;
  logic signed [65:0] s_full;
  logic               s_pos;
  abkf_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum),
                  .den(s_full[32:0]), .busy(dbusy), .quo(dq));

  assign s_full = 66'(pp00_r) + 66'($signed({1'b0, rm_r}));
  assign s_pos  = (s_full > 66'sd0);
  assign in_ready  = (st_r == abkf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (st_r == abkf_pkg::ST_OUT);
  assign out_angle_estimate = ang_r;
  assign out_bias_estimate  = bia_r;

  // One multiplier product or divider start a step; a product appears next state.
  always_comb begin
    st_nxt = st_r;
    ma = '0; mb = '0; msh30 = 1'b0;
    dstart = 1'b0; dnum = pp00_r;
    unique case (st_r)
      abkf_pkg::ST_IDLE: if (in_valid) st_nxt = abkf_pkg::ST_PA;
      abkf_pkg::ST_PA: begin
        ma = 34'(rate_r) - 34'(bia_r); mb = 34'({1'b0, dt_r});
        st_nxt = abkf_pkg::ST_P11DT;
      end
      abkf_pkg::ST_P11DT: begin
        ma = 34'(p11_r); mb = 34'({1'b0, dt_r}); st_nxt = abkf_pkg::ST_CDT;
      end
      abkf_pkg::ST_CDT: begin
        ma = 34'(pc_r); mb = 34'({1'b0, dt_r}); st_nxt = abkf_pkg::ST_P11DT2;
      end
      abkf_pkg::ST_P11DT2: begin
        ma = 34'(p11dt_r); mb = 34'({1'b0, dt_r}); st_nxt = abkf_pkg::ST_PRED;
      end
      abkf_pkg::ST_PRED: st_nxt = abkf_pkg::ST_DIV0_GO;
      abkf_pkg::ST_DIV0_GO: begin
        dstart = s_pos; dnum = pp00_r;
        st_nxt = s_pos ? abkf_pkg::ST_DIV0_WAIT : abkf_pkg::ST_GAIN;
      end
      abkf_pkg::ST_DIV0_WAIT: if (!dbusy) st_nxt = abkf_pkg::ST_DIV1_GO;
      abkf_pkg::ST_DIV1_GO: begin
        dstart = 1'b1; dnum = ppc_r; st_nxt = abkf_pkg::ST_DIV1_WAIT;
      end
      abkf_pkg::ST_DIV1_WAIT: if (!dbusy) st_nxt = abkf_pkg::ST_GAIN;
      abkf_pkg::ST_GAIN: st_nxt = abkf_pkg::ST_KY0;
      abkf_pkg::ST_KY0: begin
        ma = 34'(k0_r); mb = y_r; msh30 = 1'b1; st_nxt = abkf_pkg::ST_KY1;
      end
      abkf_pkg::ST_KY1: begin
        ma = 34'(k1_r); mb = y_r; msh30 = 1'b1; st_nxt = abkf_pkg::ST_K0P;
      end
      abkf_pkg::ST_K0P: begin
        ma = 34'(k0_r); mb = 34'(pp00_r); msh30 = 1'b1; st_nxt = abkf_pkg::ST_K0C;
      end
      abkf_pkg::ST_K0C: begin
        ma = 34'(k0_r); mb = 34'(ppc_r); msh30 = 1'b1; st_nxt = abkf_pkg::ST_K1P;
      end
      abkf_pkg::ST_K1P: begin
        ma = 34'(k1_r); mb = 34'(pp00_r); msh30 = 1'b1; st_nxt = abkf_pkg::ST_K1C;
      end
      abkf_pkg::ST_K1C: begin
        ma = 34'(k1_r); mb = 34'(ppc_r); msh30 = 1'b1; st_nxt = abkf_pkg::ST_UPD;
      end
      abkf_pkg::ST_UPD: st_nxt = abkf_pkg::ST_OUT;
      abkf_pkg::ST_OUT: if (out_ready) st_nxt = abkf_pkg::ST_IDLE;
      default: st_nxt = abkf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= abkf_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  // Datapath registers; the products capture the multiplier output of the step before.
  logic signed [65:0] ca, cb;
  always_comb begin
    ca = 66'(ppc_r) - k0c_r;
    cb = 66'(ppc_r) - k1p_r;
  end

  // Predicted angle variance before saturation.
  logic signed [65:0] pp00_sum;
  assign pp00_sum = 66'(p00_r) - (cdt_r <<< 1) + mp + 66'($signed({1'b0, qa_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= abkf_pkg::ANGLE_NOISE_RST;
      qb_r <= abkf_pkg::BIAS_NOISE_RST;
      rm_r <= abkf_pkg::MEAS_NOISE_RST;
      ang_r <= '0; bia_r <= '0; pc_r <= '0;
      p00_r <= abkf_pkg::Q24_ONE; p11_r <= abkf_pkg::Q24_ONE;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          abkf_pkg::REG_ANGLE_NOISE: qa_r <= cfg_data[30:0];
          abkf_pkg::REG_BIAS_NOISE:  qb_r <= cfg_data[30:0];
          abkf_pkg::REG_MEAS_NOISE:  rm_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (st_r == abkf_pkg::ST_UPD) begin
        ang_r <= abkf_pkg::sat32(66'(pa_r) + ky0_r);
        bia_r <= abkf_pkg::sat32(66'(bia_r) + ky1_r);
        p00_r <= abkf_pkg::sat32(66'(pp00_r) - k0p_r);
        p11_r <= abkf_pkg::sat32(66'(pp11_r) - mp);
        // Halve the sum with rounding away from zero.
        pc_r  <= abkf_pkg::sat32((ca + cb) >= 0 ? ((ca + cb) + 66'sd1) >>> 1
                                                : -((-(ca + cb) + 66'sd1) >>> 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      abkf_pkg::ST_IDLE: begin
        dt_r <= in_time_step; meas_r <= in_measured_angle; rate_r <= in_gyro_rate;
      end
      abkf_pkg::ST_P11DT: pa_r <= abkf_pkg::sat32(66'(ang_r) + mp);
      abkf_pkg::ST_CDT: p11dt_r <= mp[31:0];
      abkf_pkg::ST_P11DT2: cdt_r <= mp;
      abkf_pkg::ST_PRED: begin
        pp00_r <= abkf_pkg::sat32(pp00_sum);
        ppc_r  <= abkf_pkg::sat32(66'(pc_r) - 66'(p11dt_r));
        pp11_r <= abkf_pkg::sat32(66'(p11_r) + 66'($signed({1'b0, qb_r})));
        y_r    <= 34'(meas_r) - 34'(abkf_pkg::sat32(66'(pa_r)));
        k0_r <= '0; k1_r <= '0;
      end
      abkf_pkg::ST_DIV1_GO: k0_r <= abkf_pkg::sat32(66'(dq));
      abkf_pkg::ST_GAIN: if (spos_r) k1_r <= abkf_pkg::sat32(66'(dq));
      abkf_pkg::ST_KY1: ky0_r <= mp;
      abkf_pkg::ST_K0P: ky1_r <= mp;
      abkf_pkg::ST_K0C: k0p_r <= mp;
      abkf_pkg::ST_K1P: k0c_r <= mp;
      abkf_pkg::ST_K1C: k1p_r <= mp;
      default: ;
    endcase
  end

  // Hold the sign of the innovation variance for the gain step.
  always_ff @(posedge clk) begin
    if (st_r == abkf_pkg::ST_DIV0_GO) spos_r <= s_pos;
  end
endmodule

// File: rtl/abkf_mul.sv
// ----------------------------------------------------------------------------
// abkf_mul
// Registered signed multiply with rounding shift, ties away from zero.
// ----------------------------------------------------------------------------
module abkf_mul (
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  input  logic               sh30,
  output logic signed [65:0] p
);
  logic [33:0] ma, mb;
  logic [67:0] mp, rp;
  logic        neg;
  logic signed [65:0] p_nxt, p_r;

  always_comb begin
    ma = a[33] ? 34'(-a) : 34'(a);
    mb = b[33] ? 34'(-b) : 34'(b);
    neg = a[33] ^ b[33];
    mp = ma * mb;
    rp = sh30 ? ((mp + 68'(1 << 29)) >> 30) : ((mp + 68'(1 << 23)) >> 24);
    p_nxt = neg ? -$signed(66'(rp)) : $signed(66'(rp));
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
  assign p = p_r;
endmodule

// File: rtl/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div
// Restoring divider, one quotient bit a cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module abkf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [32:0]        den,
  output logic               busy,
  output logic signed [63:0] quo
);
  logic [61:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt;
  logic [33:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; neg_nxt = neg_r; busy_nxt = busy_r;
    trial = {rem_r, q_r[61]};
    if (start) begin
      q_nxt = {(num[31] ? 32'(-num) : 32'(num)), 30'd0};
      rem_nxt = '0; cnt_nxt = 6'd62; neg_nxt = num[31]; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = 33'(trial - {1'b0, den});
        q_nxt = {q_r[60:0], 1'b1};
      end else begin
        rem_nxt = trial[32:0];
        q_nxt = {q_r[60:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
  end

  assign busy = busy_r;
  assign quo = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
endmodule

// File: rtl/abkf_checker.sv
// ----------------------------------------------------------------------------
// abkf_checker
// Port-level checks for the Kalman filter core.
// ----------------------------------------------------------------------------
`include "angle_bias_kalman_filter_core_assert.svh"
module abkf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] out_angle_estimate
);
  `ABK_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `ABK_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
  `ABK_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_angle_estimate))
endmodule

bind angle_bias_kalman_filter_core abkf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_angle_estimate(out_angle_estimate));

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the angle/bias Kalman filter core. A fixed-point
// model of the filter predicts each angle/bias pair; every result is checked
// in order against it. The noise registers are swept, and directed, random
// and back-pressure traffic is run under several idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import abkf_pkg::*;

  typedef struct packed {
    logic [23:0]        time_step;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } estimate_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n;

  abkf_if #(.payload_t(sample_t))    in_ch ();
  abkf_if #(.payload_t(estimate_t))  out_ch ();
  abkf_if #(.payload_t(reg_write_t)) cfg_ch ();

  angle_bias_kalman_filter_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_time_step       (in_ch.data.time_step),
    .in_measured_angle  (in_ch.data.measured_angle),
    .in_gyro_rate       (in_ch.data.gyro_rate),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_angle_estimate (out_ch.data.angle_estimate),
    .out_bias_estimate  (out_ch.data.bias_estimate),
    .cfg_valid          (cfg_ch.valid),
    .cfg_ready          (cfg_ch.ready),
    .cfg_index          (cfg_ch.data.index),
    .cfg_data           (cfg_ch.data.data)
  );

  // Free-running clock, period 20.
  always #10 clk = ~clk;

  // Filter model: noise registers and the five state words.
  longint unsigned angle_noise, bias_noise, meas_noise;
  longint est_angle, est_bias, var_angle, cov_cross, var_bias;

  estimate_t expected_estimates[$];
  int        mismatches;

  // Idling percentages for the sender and the receiver.
  int send_idle_pct;
  int recv_stall_pct;

  // Long receiver hold-off: the test bumps the request count, the hold
  // process counts the stretch itself.
  int hold_requests;
  int hold_served;
  int hold_left;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact product shifted right by n, rounded half away from zero.
  function automatic longint round_shift_mul(longint a, longint b, int n);
    longint unsigned mag;
    bit neg;
    mag = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    neg = (a < 0) != (b < 0);
    if (n > 0) mag = (mag + (64'd1 << (n - 1))) >> n;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  task automatic filter_reset();
    angle_noise = ANGLE_NOISE_RST;
    bias_noise  = BIAS_NOISE_RST;
    meas_noise  = MEAS_NOISE_RST;
    est_angle   = 0;
    est_bias    = 0;
    var_angle   = Q24_ONE;
    cov_cross   = 0;
    var_bias    = Q24_ONE;
  endtask

  // Advance the filter by one sample and return the corrected estimates.
  function automatic estimate_t filter_update(sample_t s);
    longint dt, pa, pb, p11dt, p00, pc, p11, inno, k0, k1, y, ca, cb;
    estimate_t e;
    dt = s.time_step;
    // predict state
    pa = clamp32(est_angle + round_shift_mul(longint'(s.gyro_rate) - est_bias, dt, 24));
    pb = est_bias;
    // predict covariance; noise is not scaled by dt
    p11dt = round_shift_mul(var_bias, dt, 24);
    p00 = clamp32(var_angle - 2 * round_shift_mul(cov_cross, dt, 24)
                  + round_shift_mul(p11dt, dt, 24) + longint'(angle_noise));
    pc  = clamp32(cov_cross - p11dt);
    p11 = clamp32(var_bias + longint'(bias_noise));
    // gain in Q2.30, zero when the innovation variance is not positive
    inno = p00 + longint'(meas_noise);
    k0 = 0;
    k1 = 0;
    if (inno > 0) begin
      k0 = clamp32((p00 * 64'sd1073741824) / inno);
      k1 = clamp32((pc * 64'sd1073741824) / inno);
    end
    // correct
    y = longint'(s.measured_angle) - pa;
    est_angle = clamp32(pa + round_shift_mul(k0, y, 30));
    est_bias  = clamp32(pb + round_shift_mul(k1, y, 30));
    // covariance update, cross term averaged to keep it symmetric
    ca = pc - round_shift_mul(k0, pc, 30);
    cb = pc - round_shift_mul(k1, p00, 30);
    var_angle = clamp32(p00 - round_shift_mul(k0, p00, 30));
    cov_cross = clamp32(round_shift_mul(ca + cb, 1, 1));
    var_bias  = clamp32(p11 - round_shift_mul(k1, pc, 30));
    e.angle_estimate = est_angle[31:0];
    e.bias_estimate  = est_bias[31:0];
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  // Receiver: random stalls, or a long hold while a request is being served.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= 600;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: compare each accepted item with the oldest estimate.
  always @(posedge clk) begin
    estimate_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_estimates.size() == 0) begin
        mismatches++;
        $display("ERROR %0t: unexpected result item", $time);
      end else begin
        want = expected_estimates.pop_front();
        if (out_ch.data.angle_estimate !== want.angle_estimate)
          report_mismatch("angle_estimate", out_ch.data.angle_estimate, want.angle_estimate);
        if (out_ch.data.bias_estimate !== want.bias_estimate)
          report_mismatch("bias_estimate", out_ch.data.bias_estimate, want.bias_estimate);
      end
    end
  end

  // Offer one sample, idling first at random; valid stays high afterwards
  // so back-to-back items need no second assignment in the same step.
  task automatic send_sample(sample_t s);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_estimates.push_back(filter_update(s));
  endtask

  // Drop valid, wait for every result, then let the core settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ANGLE_NOISE: angle_noise = value[30:0];
      REG_BIAS_NOISE:  bias_noise  = value[30:0];
      REG_MEAS_NOISE:  meas_noise  = value[30:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_noise(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    write_reg(REG_ANGLE_NOISE, a);
    write_reg(REG_BIAS_NOISE, b);
    write_reg(REG_MEAS_NOISE, m);
  endtask

  // Mostly realistic values, sometimes the full range or an extreme.
  function automatic logic [31:0] pick_word(int small_max);
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(2 * small_max) - small_max;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(7))
      0: s.time_step = 24'($urandom());
      1: s.time_step = '0;
      default: s.time_step = 24'($urandom_range(400000));
    endcase
    s.measured_angle = pick_word(90 << 16);
    s.gyro_rate      = pick_word(500 << 16);
    return s;
  endfunction

  task automatic test_register_writes();
    set_noise(32'h8000_0000, 32'hffff_ffff, 32'h0000_0001);
    write_reg(2'd3, 32'h1234_5678);  // unmapped index: ignored
    send_sample('{24'd16777, 32'sd65536, 32'sd0});
    send_sample('{24'd16777, -32'sd65536, 32'sd1000});
    drain();
  endtask

  task automatic test_directed();
    set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
    send_sample('{24'd0, 32'sd0, 32'sd0});
    send_sample('{24'd0, 32'sh7fffffff, 32'sh7fffffff});
    send_sample('{24'hffffff, 32'sh80000000, 32'sh80000000});
    send_sample('{24'hffffff, 32'sh7fffffff, 32'sh80000000});
    send_sample('{24'hffffff, 32'sh80000000, 32'sh7fffffff});
    send_sample('{24'd16777, 32'sd5 << 16, -32'sd3 << 16});
    send_sample('{24'haaaaaa, 32'h5555_5555, 32'haaaa_aaaa});
    send_sample('{24'h555555, 32'haaaa_aaaa, 32'h5555_5555});
    drain();
    // All noise zero: the angle variance collapses and the innovation
    // variance reaches zero, so the gains drop to zero.
    set_noise(0, 0, 0);
    repeat (8) send_sample('{24'd0, 32'sd1 << 16, 32'sd0});
    send_sample('{24'd1000, -32'sd1 << 16, 32'sd7});
    drain();
    // Largest noise values.
    set_noise(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    repeat (3) send_sample(random_sample());
    drain();
  endtask

  task automatic run_random(int count);
    repeat (count) send_sample(random_sample());
    drain();
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;
    set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
    run_random(350);
    send_idle_pct = 52; recv_stall_pct = 0;
    set_noise(167772, 83886, 3355443);  // yaw noise set
    run_random(350);
    send_idle_pct = 0;  recv_stall_pct = 52;
    set_noise($urandom(), $urandom(), $urandom_range(1 << 26, 1));
    run_random(330);
    send_idle_pct = 33; recv_stall_pct = 33;
    set_noise($urandom_range(1 << 20), $urandom_range(1 << 20), $urandom());
    run_random(330);
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    set_noise(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST);
    hold_requests++;
    repeat (6) send_sample(random_sample());
    // pause the sender until every result is back
    drain();
    repeat (4) send_sample(random_sample());
    drain();
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.data     <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.data    <= '0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    hold_served    = 0;
    filter_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_writes();
    test_directed();
    test_random_phases();
    test_back_pressure();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: angle_bias_kalman_filter_core.f
+incdir+rtl
rtl/abkf_pkg.sv
rtl/abkf_if.sv
rtl/abkf_mul.sv
rtl/abkf_div.sv
rtl/angle_bias_kalman_filter_core.sv
rtl/abkf_checker.sv
verif/testbench.sv
